/* hw/rtl/bive_pkg.sv */
// Shared types and constants for the bounded vector engine.
package bive_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned KindW  = 3;
  localparam int unsigned IndexW = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;

  localparam logic [KindW-1:0] KIND_SET  = 3'd0;
  localparam logic [KindW-1:0] KIND_GET  = 3'd1;
  localparam logic [KindW-1:0] KIND_PUSH = 3'd2;
  localparam logic [KindW-1:0] KIND_POP  = 3'd3;
  localparam logic [KindW-1:0] KIND_FIND = 3'd4;
  localparam logic [KindW-1:0] KIND_SORT = 3'd5;
  // Spare codes: served as no-ops.
  localparam logic [KindW-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE_B = 3'd7;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_BADINDEX = 2'd1;
  localparam logic [StatW-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [StatW-1:0] ST_FULL     = 2'd3;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       latch;    // capture request
    logic       rd_req;   // read at request index
    logic       rd_top;   // read at length-1
    logic       wr_req;   // write request value at request index
    logic       wr_push;  // write request value at length
    logic       len_inc;
    logic       len_dec;
    logic       i_clr;    // i := 0
    logic       i_inc;
    logic       j_ld;     // j := i+1, best := i (best_val set by take_ent)
    logic       rd_i;     // read mem[i]
    logic       rd_j;     // read mem[j]
    logic       rd_best;  // read mem[best]
    logic       take_ent; // cur_ent, best_val := rdata (at i)
    logic       cmp_j;    // compare rdata (j) with best_val, update
    logic       j_inc;
    logic       wr_i_best;// mem[i] := best_val
    logic       wr_best_i;// mem[best] := cur_ent
    logic       k_clr;
    logic       k_inc;
    logic       rd_k;
    logic       res_sel;  // 0 zero, 1 result register
    logic       res_rd;   // result register := rdata
    logic       res_k;    // result register := k
  } bive_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic idx_ok;
    logic empty;
    logic full;
    logic i_done;    // i >= length
    logic j_done;    // j >= length
    logic k_done;    // k >= length
    logic match;     // rdata == value
    logic best_moved;// best != i
  } bive_sts_t;

endpackage

/* hw/rtl/bive_datapath.sv */
// Datapath: entry memory, length, sort and find counters, result register.
module bive_datapath #(
  parameter int unsigned Depth = bive_pkg::DefaultDepth,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned LW = $clog2(Depth + 1),
  localparam int unsigned CW = (LW > bive_pkg::IndexW) ? LW : bive_pkg::IndexW
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [bive_pkg::KindW-1:0]  kind_i,
  input  logic [bive_pkg::IndexW-1:0] index_i,
  input  logic signed [bive_pkg::DataW-1:0] value_i,
  input  bive_pkg::bive_cmd_t cmd_i,
  output bive_pkg::bive_sts_t sts_o,
  output logic signed [bive_pkg::DataW-1:0] result_value_o
);

  logic [bive_pkg::DataW-1:0] mem [Depth];
  logic [bive_pkg::DataW-1:0] rdata_q;
  logic [bive_pkg::KindW-1:0]  kind_q;
  logic [bive_pkg::IndexW-1:0] index_q;
  logic [bive_pkg::DataW-1:0]  value_q;
  logic [LW-1:0] len_q, i_q, j_q, k_q, best_q;
  logic [bive_pkg::DataW-1:0] best_val_q, cur_q, res_q;
  logic [CW-1:0] idx_ext;
  logic [LW-1:0] top;
  logic [AW-1:0] raddr, waddr;
  logic [bive_pkg::DataW-1:0] wdata;
  logic we, re;

  assign idx_ext = CW'(index_q);
  assign top     = len_q - LW'(1);

  always_comb begin
    re    = 1'b1;
    raddr = AW'(i_q);
    if (cmd_i.rd_req)       raddr = AW'(idx_ext);
    else if (cmd_i.rd_top)  raddr = AW'(top);
    else if (cmd_i.rd_j)    raddr = AW'(j_q);
    else if (cmd_i.rd_best) raddr = AW'(best_q);
    else if (cmd_i.rd_k)    raddr = AW'(k_q);
    else if (!cmd_i.rd_i)   re = 1'b0;
    we    = 1'b1;
    waddr = AW'(idx_ext);
    wdata = value_q;
    if (cmd_i.wr_push) begin
      waddr = AW'(len_q);
    end else if (cmd_i.wr_i_best) begin
      waddr = AW'(i_q);
      wdata = best_val_q;
    end else if (cmd_i.wr_best_i) begin
      waddr = AW'(best_q);
      wdata = cur_q;
    end else if (!cmd_i.wr_req) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_i;
      index_q <= index_i;
      value_q <= value_i;
    end
    if (cmd_i.take_ent) begin
      cur_q      <= rdata_q;
      best_val_q <= rdata_q;
    end
    if (cmd_i.cmp_j && $signed(rdata_q) < $signed(best_val_q)) begin
      best_val_q <= rdata_q;
    end
    if (cmd_i.res_rd) res_q <= rdata_q;
    if (cmd_i.res_k)  res_q <= bive_pkg::DataW'(k_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      best_q <= '0;
    end else begin
      if (cmd_i.len_inc) len_q <= len_q + LW'(1);
      if (cmd_i.len_dec) len_q <= top;
      if (cmd_i.i_clr) i_q <= '0;
      if (cmd_i.i_inc) i_q <= i_q + LW'(1);
      if (cmd_i.j_ld) begin
        j_q    <= i_q + LW'(1);
        best_q <= i_q;
      end
      if (cmd_i.cmp_j && $signed(rdata_q) < $signed(best_val_q)) best_q <= j_q;
      if (cmd_i.j_inc) j_q <= j_q + LW'(1);
      if (cmd_i.k_clr) k_q <= '0;
      if (cmd_i.k_inc) k_q <= k_q + LW'(1);
    end
  end

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.idx_ok     = idx_ext < CW'(len_q);
    sts_o.empty      = len_q == '0;
    sts_o.full       = len_q >= LW'(Depth);
    sts_o.i_done     = i_q >= len_q;
    sts_o.j_done     = j_q >= len_q;
    sts_o.k_done     = k_q >= len_q;
    sts_o.match      = rdata_q == value_q;
    sts_o.best_moved = best_q != i_q;
  end

  assign result_value_o = cmd_i.res_sel ? res_q : '0;

endmodule

/* hw/rtl/bive_ctrl.sv */
// Controller state machine sequencing each request over the datapath.
module bive_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output logic [bive_pkg::StatW-1:0] status_o,
  input  bive_pkg::bive_sts_t sts_i,
  output bive_pkg::bive_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DISP   = 12'b000000000010,
    S_RDWAIT = 12'b000000000100,
    S_FRD    = 12'b000000001000,
    S_FCHK   = 12'b000000010000,
    S_SI     = 12'b000000100000,
    S_SIWAIT = 12'b000001000000,
    S_SJ     = 12'b000010000000,
    S_SCMP   = 12'b000100000000,
    S_SWAP   = 12'b001000000000,
    S_SNEXT  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [bive_pkg::StatW-1:0] st_q, st_d;
  logic res_q, res_d;

  assign busy_o   = state_q != S_IDLE;
  assign done_o   = state_q == S_DONE;
  assign status_o = st_q;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res_sel = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        st_d  = bive_pkg::ST_OK;
        res_d = 1'b0;
        state_d = S_DONE;
        unique case (sts_i.kind)
          bive_pkg::KIND_SET: begin
            if (sts_i.idx_ok) cmd_o.wr_req = 1'b1;
            else st_d = bive_pkg::ST_BADINDEX;
          end
          bive_pkg::KIND_GET: begin
            if (sts_i.idx_ok) begin
              cmd_o.rd_req = 1'b1;
              state_d = S_RDWAIT;
            end else st_d = bive_pkg::ST_BADINDEX;
          end
          bive_pkg::KIND_PUSH: begin
            if (sts_i.full) st_d = bive_pkg::ST_FULL;
            else begin
              cmd_o.wr_push = 1'b1;
              cmd_o.len_inc = 1'b1;
            end
          end
          bive_pkg::KIND_POP: begin
            if (sts_i.empty) st_d = bive_pkg::ST_BADINDEX;
            else begin
              cmd_o.rd_top  = 1'b1;
              cmd_o.len_dec = 1'b1;
              state_d = S_RDWAIT;
            end
          end
          bive_pkg::KIND_FIND: begin
            cmd_o.k_clr = 1'b1;
            state_d = S_FRD;
          end
          bive_pkg::KIND_SORT: begin
            cmd_o.i_clr = 1'b1;
            state_d = S_SI;
          end
          default: ;
        endcase
      end
      S_RDWAIT: begin
        cmd_o.res_rd = 1'b1;
        res_d = 1'b1;
        state_d = S_DONE;
      end
      S_FRD: begin
        if (sts_i.k_done) begin
          st_d = bive_pkg::ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_k = 1'b1;
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts_i.match) begin
          cmd_o.res_k = 1'b1;
          res_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d = S_FRD;
        end
      end
      S_SI: begin
        if (sts_i.i_done) state_d = S_DONE;
        else begin
          cmd_o.rd_i = 1'b1;
          cmd_o.j_ld = 1'b1;
          state_d = S_SIWAIT;
        end
      end
      S_SIWAIT: begin
        cmd_o.take_ent = 1'b1;
        state_d = S_SJ;
      end
      S_SJ: begin
        if (sts_i.j_done) state_d = S_SWAP;
        else begin
          cmd_o.rd_j = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd_o.cmp_j = 1'b1;
        cmd_o.j_inc = 1'b1;
        state_d = S_SJ;
      end
      S_SWAP: begin
        if (sts_i.best_moved) begin
          cmd_o.wr_i_best = 1'b1;
          state_d = S_SNEXT;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_SI;
        end
      end
      S_SNEXT: begin
        cmd_o.wr_best_i = 1'b1;
        cmd_o.i_inc = 1'b1;
        state_d = S_SI;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= bive_pkg::ST_OK;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      res_q   <= res_d;
    end
  end

endmodule

/* hw/rtl/bounded_int_vector_engine.sv */
// Bounded vector engine: serves set, get, push, pop, find and sort requests,
// one at a time; find and sort walk the entry memory one word at a time.
// The next request is taken the cycle after done_o. No backpressure on results.
// Reset clears the length and controller; entries stay undefined until written.
module bounded_int_vector_engine #(
  parameter int unsigned DEPTH = bive_pkg::DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic [bive_pkg::KindW-1:0]  kind_i,
  input  logic [bive_pkg::IndexW-1:0] index_i,
  input  logic signed [bive_pkg::DataW-1:0] value_i,
  output logic done_o,
  output logic [bive_pkg::StatW-1:0] status_o,
  output logic signed [bive_pkg::DataW-1:0] result_value_o
);

  bive_pkg::bive_cmd_t cmd;
  bive_pkg::bive_sts_t sts;

  bive_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o,
    .status_o, .sts_i(sts), .cmd_o(cmd)
  );

  bive_datapath #(.Depth(DEPTH)) u_dp (
    .clk_i, .rst_ni, .kind_i, .index_i, .value_i,
    .cmd_i(cmd), .sts_o(sts), .result_value_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bive_pkg::ST_OK) |-> result_value_o == '0)
    else $error("non-zero result on error");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the bounded vector engine.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Depth = bive_pkg::DefaultDepth;

  typedef struct packed {
    logic [bive_pkg::KindW-1:0]        kind;
    logic [bive_pkg::IndexW-1:0]       index;
    logic signed [bive_pkg::DataW-1:0] value;
  } vec_req_t;

  typedef struct packed {
    logic [bive_pkg::StatW-1:0]        status;
    logic signed [bive_pkg::DataW-1:0] value;
  } vec_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [bive_pkg::KindW-1:0] kind_i = '0;
  logic [bive_pkg::IndexW-1:0] index_i = '0;
  logic signed [bive_pkg::DataW-1:0] value_i = '0;
  logic done_o;
  logic [bive_pkg::StatW-1:0] status_o;
  logic signed [bive_pkg::DataW-1:0] result_value_o;

  vec_req_t  pending_reqs[$];
  vec_resp_t expected_resps[$];
  logic signed [bive_pkg::DataW-1:0] shadow_mem[Depth];
  int unsigned shadow_len;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  bit quiet_mode = 1'b0;
  bit hold_sender = 1'b0;
  logic took_q = 1'b0;

  bounded_int_vector_engine #(.DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .index_i, .value_i,
    .done_o, .status_o, .result_value_o
  );

  always #6 clk_i = ~clk_i;

  // Apply one request to the shadow vector and return the response it causes.
  function automatic vec_resp_t predict_vector(vec_req_t r);
    vec_resp_t rsp;
    logic signed [bive_pkg::DataW-1:0] tmp;
    int unsigned best;
    rsp = '{status: bive_pkg::ST_OK, value: '0};
    case (r.kind)
      bive_pkg::KIND_SET: begin
        if (r.index < shadow_len) shadow_mem[r.index] = r.value;
        else rsp.status = bive_pkg::ST_BADINDEX;
      end
      bive_pkg::KIND_GET: begin
        if (r.index < shadow_len) rsp.value = shadow_mem[r.index];
        else rsp.status = bive_pkg::ST_BADINDEX;
      end
      bive_pkg::KIND_PUSH: begin
        if (shadow_len >= Depth) rsp.status = bive_pkg::ST_FULL;
        else begin
          shadow_mem[shadow_len] = r.value;
          shadow_len++;
        end
      end
      bive_pkg::KIND_POP: begin
        if (shadow_len == 0) rsp.status = bive_pkg::ST_BADINDEX;
        else begin
          shadow_len--;
          rsp.value = shadow_mem[shadow_len];
        end
      end
      bive_pkg::KIND_FIND: begin
        rsp.status = bive_pkg::ST_NOTFOUND;
        for (int unsigned k = 0; k < shadow_len; k++) begin
          if (shadow_mem[k] == r.value) begin
            rsp.status = bive_pkg::ST_OK;
            rsp.value = bive_pkg::DataW'(k);
            break;
          end
        end
      end
      bive_pkg::KIND_SORT: begin
        for (int unsigned i = 0; i < shadow_len; i++) begin
          best = i;
          for (int unsigned j = i + 1; j < shadow_len; j++)
            if (shadow_mem[j] < shadow_mem[best]) best = j;
          tmp = shadow_mem[i];
          shadow_mem[i] = shadow_mem[best];
          shadow_mem[best] = tmp;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Acceptance at the rising edge: predict from what the ports carried.
  always @(posedge clk_i) begin
    vec_req_t acc_r;
    if (rst_ni && start && !busy) begin
      acc_r.kind  = kind_i;
      acc_r.index = index_i;
      acc_r.value = value_i;
      void'(pending_reqs.pop_front());
      expected_resps.push_back(predict_vector(acc_r));
      took_q <= 1'b1;
    end else begin
      took_q <= 1'b0;
    end
  end

  // Driver: hold a request until taken, then offer the next or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took_q)) begin
      if (pending_reqs.size() > 0 && !hold_sender &&
          (quiet_mode || $urandom_range(99) >= 20)) begin
        kind_i  <= pending_reqs[0].kind;
        index_i <= pending_reqs[0].index;
        value_i <= pending_reqs[0].value;
        start   <= 1'b1;
      end else begin
        start   <= 1'b0;
        kind_i  <= bive_pkg::KindW'($urandom);
        index_i <= bive_pkg::IndexW'($urandom);
        value_i <= $urandom;
      end
    end
  end

  // Monitor: check each response against the oldest expectation.
  always @(posedge clk_i) begin
    vec_resp_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected response status=%0d value=%0d", status_o, result_value_o);
        n_errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        n_checked++;
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          n_errors++;
        end
        if (result_value_o !== exp_r.value) begin
          $error("result_value: expected %0d, actual %0d", exp_r.value, result_value_o);
          n_errors++;
        end
      end
    end
  end

  function automatic vec_req_t mk_req(logic [bive_pkg::KindW-1:0] k, int unsigned idx,
                                      logic signed [bive_pkg::DataW-1:0] v);
    vec_req_t r;
    r.kind = k;
    r.index = bive_pkg::IndexW'(idx);
    r.value = v;
    return r;
  endfunction

  // Random value, biased towards a small pool so that find hits often.
  function automatic logic signed [bive_pkg::DataW-1:0] rand_value();
    case ($urandom_range(3))
      0: return $signed($urandom_range(15)) - 8;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_resps.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic wait_room();
    if (pending_reqs.size() > 8)
      while (pending_reqs.size() > 4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned model_len;
    int unsigned pick;
    logic [bive_pkg::KindW-1:0] k;
    for (int i = 0; i < Depth; i++) shadow_mem[i] = '0;
    shadow_len = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-vector corners, extremes, every request kind.
    pending_reqs.push_back(mk_req(bive_pkg::KIND_POP, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_GET, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SET, 0, 5));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_FIND, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SORT, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_PUSH, 0, 32'sh7fffffff));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_PUSH, 1023, 32'sh80000000));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_PUSH, 0, -1));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_PUSH, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_GET, 1, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_GET, 4, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SET, 3, 32'sh55aa55aa));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SET, 1023, 1));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_FIND, 0, -1));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_FIND, 0, 12345));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SORT, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_GET, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_GET, 3, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SPARE_A, 1023, -1));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SPARE_B, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_POP, 0, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_FIND, 0, 32'sh7fffffff));
    model_len = 3;

    // Wait until the engine has answered everything, then hold the sender idle.
    wait_drained();
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;

    // Random: keep the vector short so sort stays cheap.
    for (int n = 0; n < 110; n++) begin
      quiet_mode = (n >= 40 && n < 80);
      pick = $urandom_range(99);
      if (pick < 25) k = bive_pkg::KIND_PUSH;
      else if (pick < 40) k = bive_pkg::KIND_POP;
      else if (pick < 58) k = bive_pkg::KIND_SET;
      else if (pick < 76) k = bive_pkg::KIND_GET;
      else if (pick < 92) k = bive_pkg::KIND_FIND;
      else if (pick < 97) k = bive_pkg::KIND_SORT;
      else k = $urandom_range(1) ? bive_pkg::KIND_SPARE_A : bive_pkg::KIND_SPARE_B;
      if (k == bive_pkg::KIND_PUSH && model_len > 24) k = bive_pkg::KIND_POP;
      if (k == bive_pkg::KIND_PUSH) model_len++;
      if (k == bive_pkg::KIND_POP && model_len > 0) model_len--;
      pending_reqs.push_back(mk_req(k,
        ($urandom_range(9) == 0) ? $urandom : $urandom_range(model_len + 1),
        rand_value()));
      wait_room();
    end
    wait_drained();
    quiet_mode = 1'b0;

    // Fill to capacity once to see full, with a stretch of back-to-back offers.
    for (int n = model_len; n < Depth + 2; n++) begin
      quiet_mode = (n >= 300 && n < 600);
      pending_reqs.push_back(mk_req(bive_pkg::KIND_PUSH, 0, $urandom));
      wait_room();
    end
    quiet_mode = 1'b0;
    pending_reqs.push_back(mk_req(bive_pkg::KIND_GET, 1023, 0));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_SET, 1023, 32'sh80000000));
    pending_reqs.push_back(mk_req(bive_pkg::KIND_FIND, 0, 32'sh80000000));
    wait_drained();

    repeat (50) @(posedge clk_i);
    $display("checked %0d responses, including empty, full and sorted vectors",
             n_checked);
    if (n_errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
